/* sv/bft_pkg.sv */
// Package with the hash, the bucket entry layout and the lookup status codes of the flow table.
package bft_pkg;

  localparam int unsigned HashMul   = 59;
  localparam int unsigned PortShift = 16;

  typedef enum logic [1:0] {
    StatusNew     = 2'd0,
    StatusFwdHit  = 2'd1,
    StatusRevHit  = 2'd2,
    StatusDropped = 2'd3
  } status_e;

  // Flow key as stored in one way: protocol, ports (source high), destination, source.
  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] ports;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } flow_key_t;

  localparam int unsigned KeyBits = $bits(flow_key_t);

  function automatic logic [31:0] flow_hash(
    input logic [31:0] sa,
    input logic [31:0] da,
    input logic [15:0] sp,
    input logic [15:0] dp,
    input logic [7:0]  pr
  );
    logic [31:0] a;
    logic [31:0] p;
    a = (sa ^ da) * 32'(HashMul);
    p = 32'(sp ^ dp) << PortShift;
    return a ^ p ^ {24'h000000, pr};
  endfunction

endpackage

/* sv/bft_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/bidirectional_flow_table.sv */
// Top level of the bidirectional flow table: hash, bucket read, match and write back.
//
// Each packet 5-tuple is hashed symmetrically into one of BUCKETS buckets of WAYS slots.
// A transaction runs in order: the hash is registered, the whole bucket is read
// from the key and counter memories (one word holds all ways of a bucket), then the ways
// are compared, the counters updated and the bucket written back. The next packet is taken
// only after that write-back, once the result register is free or being emptied, so no new
// packet is accepted while one is in flight. A valid bit per slot lives in a third
// memory; after reset a clearing pass writes every bucket to empty, during which no packet
// is accepted.
module bidirectional_flow_table #(
  parameter int unsigned BUCKETS    = 1024,
  parameter int unsigned WAYS       = 4,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // source_address[31:0], dest_address[63:32], source_port[79:64], dest_port[95:80],
  // protocol_number[103:96]
  input  logic [103:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // lookup_status[1:0], bucket_index[11:2], slot_index[13:12], total_packets[45:14],
  // outbound_packets[77:46], inbound_packets[109:78], zero fill up to 111
  output logic [111:0]  m_axis_tdata
);
  import bft_pkg::*;

  localparam int unsigned BktBits = $clog2(BUCKETS);
  localparam int unsigned WayBits = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CntW    = 3 * COUNT_BITS;

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StRead  = 4'b0100,
    StMod   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [BktBits-1:0] clr_q;
  logic [31:0]  sa_q, da_q;
  logic [15:0]  sp_q, dp_q;
  logic [7:0]   pr_q;
  logic [BktBits-1:0] bkt_q;

  logic                    vld_we, key_we;
  logic [BktBits-1:0]      waddr;
  logic [WAYS-1:0]         vld_wdata, vld_rdata;
  logic [WAYS*KeyBits-1:0] key_wdata, key_rdata;
  logic [WAYS*CntW-1:0]    cnt_wdata, cnt_rdata;
  logic                    rd_en;

  logic        out_vld_q;
  logic [1:0]  o_status_q;
  logic [9:0]  o_bkt_q;
  logic [1:0]  o_slot_q;
  logic [31:0] o_tot_q, o_out_q, o_in_q;

  logic [31:0] hash;
  assign hash = flow_hash(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[79:64],
                          s_axis_tdata[95:80], s_axis_tdata[103:96]);

  assign s_axis_tready = (state_q == StIdle) && (!out_vld_q || m_axis_tready);
  assign rd_en = (state_q == StRead);

  bft_ram #(.Width(WAYS), .Depth(BUCKETS)) u_vld (
    .clk_i, .we_i(vld_we), .waddr_i(waddr), .wdata_i(vld_wdata),
    .re_i(rd_en), .raddr_i(bkt_q), .rdata_o(vld_rdata));
  bft_ram #(.Width(WAYS*KeyBits), .Depth(BUCKETS)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(bkt_q), .wdata_i(key_wdata),
    .re_i(rd_en), .raddr_i(bkt_q), .rdata_o(key_rdata));
  bft_ram #(.Width(WAYS*CntW), .Depth(BUCKETS)) u_cnt (
    .clk_i, .we_i(key_we), .waddr_i(bkt_q), .wdata_i(cnt_wdata),
    .re_i(rd_en), .raddr_i(bkt_q), .rdata_o(cnt_rdata));

  // Match logic over the ways of the bucket just read.
  flow_key_t fwd_key, rev_key;
  assign fwd_key = '{protocol: pr_q, ports: {sp_q, dp_q}, dst_addr: da_q, src_addr: sa_q};
  assign rev_key = '{protocol: pr_q, ports: {dp_q, sp_q}, dst_addr: sa_q, src_addr: da_q};

  logic                  hit, hit_fwd, has_free;
  logic [WayBits-1:0]    hit_way, free_way, sel_way;
  logic [COUNT_BITS-1:0] new_t, new_o, new_n;
  logic [1:0]            status;

  always_comb begin
    flow_key_t k;
    logic [CntW-1:0] c;
    logic [COUNT_BITS-1:0] ct, co, cn;
    hit = 1'b0;
    hit_fwd = 1'b0;
    has_free = 1'b0;
    hit_way = '0;
    free_way = '0;
    ct = '0;
    co = '0;
    cn = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      k = key_rdata[w*KeyBits +: KeyBits];
      c = cnt_rdata[w*CntW +: CntW];
      if (!vld_rdata[w]) begin
        has_free = 1'b1;
        free_way = WayBits'(w);
      end else if (k == fwd_key || k == rev_key) begin
        hit = 1'b1;
        hit_fwd = (k == fwd_key);
        hit_way = WayBits'(w);
        ct = c[0 +: COUNT_BITS];
        co = c[COUNT_BITS +: COUNT_BITS];
        cn = c[2*COUNT_BITS +: COUNT_BITS];
      end
    end
    new_t = '0;
    new_o = '0;
    new_n = '0;
    sel_way = '0;
    if (hit) begin
      sel_way = hit_way;
      new_t = ct + 1'b1;
      new_o = hit_fwd ? co + 1'b1 : co;
      new_n = hit_fwd ? cn : cn + 1'b1;
      status = hit_fwd ? StatusFwdHit : StatusRevHit;
    end else if (has_free) begin
      sel_way = free_way;
      new_t = COUNT_BITS'(1);
      new_o = COUNT_BITS'(1);
      status = StatusNew;
    end else begin
      status = StatusDropped;
    end
  end

  always_comb begin
    vld_we = 1'b0;
    key_we = 1'b0;
    waddr = bkt_q;
    vld_wdata = vld_rdata;
    key_wdata = key_rdata;
    cnt_wdata = cnt_rdata;
    if (state_q == StClear) begin
      vld_we = 1'b1;
      waddr = clr_q;
      vld_wdata = '0;
    end else if (state_q == StMod && status != StatusDropped) begin
      vld_we = 1'b1;
      key_we = 1'b1;
      vld_wdata[sel_way] = 1'b1;
      if (!hit) begin
        key_wdata[sel_way*KeyBits +: KeyBits] = fwd_key;
      end
      cnt_wdata[sel_way*CntW +: CntW] = {new_n, new_o, new_t};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_q == BktBits'(BUCKETS - 1)) state_d = StIdle;
      StIdle:  if (s_axis_tvalid && s_axis_tready) state_d = StRead;
      StRead:  state_d = StMod;
      StMod:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == StMod) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sa_q  <= s_axis_tdata[31:0];
      da_q  <= s_axis_tdata[63:32];
      sp_q  <= s_axis_tdata[79:64];
      dp_q  <= s_axis_tdata[95:80];
      pr_q  <= s_axis_tdata[103:96];
      bkt_q <= hash[BktBits-1:0];
    end
    if (state_q == StMod) begin
      o_status_q <= status;
      o_bkt_q    <= 10'(bkt_q);
      o_slot_q   <= 2'(sel_way);
      o_tot_q    <= 32'(new_t);
      o_out_q    <= 32'(new_o);
      o_in_q     <= 32'(new_n);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, o_in_q, o_out_q, o_tot_q, o_slot_q, o_bkt_q, o_status_q};

endmodule

/* verif/tb_bidirectional_flow_table.sv */
// Testbench for the bidirectional flow table: directed and random packet streams checked per result.
`timescale 1ns / 1ps

module tb_bidirectional_flow_table;
  import bft_pkg::*;

  localparam int unsigned NumBuckets = 1024;
  localparam int unsigned NumWays    = 4;
  localparam int unsigned NumEntries = NumBuckets * NumWays;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } packet_t;

  typedef struct packed {
    logic [1:0]  fill;
    logic [31:0] inbound;
    logic [31:0] outbound;
    logic [31:0] total;
    logic [1:0]  slot;
    logic [9:0]  bucket;
    status_e     status;
  } lookup_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [111:0]  m_axis_tdata;

  // Shadow copy of the flow table.
  logic          shadow_valid [NumEntries];
  flow_key_t     shadow_key   [NumEntries];
  logic [31:0]   shadow_total [NumEntries];
  logic [31:0]   shadow_out   [NumEntries];
  logic [31:0]   shadow_in    [NumEntries];

  lookup_t       pending_lookups [$];
  packet_t       known_flows [$];
  int unsigned   error_count;
  int unsigned   packets_sent;
  int unsigned   results_seen;
  int unsigned   hit_count;
  int unsigned   drop_count;
  int unsigned   hold_cycles;
  bit            stall_enable;

  bidirectional_flow_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic lookup_t predict_lookup(packet_t pkt);
    lookup_t     res;
    logic [31:0] h;
    logic [31:0] fwd_ports;
    logic [31:0] rev_ports;
    int          free_way;
    int          base;
    int          e;
    h = ((pkt.src_addr ^ pkt.dst_addr) * 32'd59) ^ {(pkt.src_port ^ pkt.dst_port), 16'h0000}
        ^ {24'h0, pkt.protocol};
    fwd_ports = {pkt.src_port, pkt.dst_port};
    rev_ports = {pkt.dst_port, pkt.src_port};
    res = '0;
    res.status = StatusDropped;
    res.bucket = h[9:0];
    base = int'(res.bucket) * NumWays;
    free_way = -1;
    for (int w = 0; w < NumWays; w++) begin
      e = base + w;
      if (!shadow_valid[e]) begin
        if (free_way < 0) free_way = w;
        continue;
      end
      if (shadow_key[e].protocol != pkt.protocol) continue;
      if (shadow_key[e].src_addr == pkt.src_addr && shadow_key[e].dst_addr == pkt.dst_addr &&
          shadow_key[e].ports == fwd_ports) begin
        shadow_total[e]++;
        shadow_out[e]++;
        res.status = StatusFwdHit;
      end else if (shadow_key[e].src_addr == pkt.dst_addr &&
                   shadow_key[e].dst_addr == pkt.src_addr &&
                   shadow_key[e].ports == rev_ports) begin
        shadow_total[e]++;
        shadow_in[e]++;
        res.status = StatusRevHit;
      end else begin
        continue;
      end
      res.slot     = w[1:0];
      res.total    = shadow_total[e];
      res.outbound = shadow_out[e];
      res.inbound  = shadow_in[e];
      return res;
    end
    if (free_way >= 0) begin
      e = base + free_way;
      shadow_valid[e] = 1'b1;
      shadow_key[e]   = '{protocol: pkt.protocol, ports: fwd_ports,
                          dst_addr: pkt.dst_addr, src_addr: pkt.src_addr};
      shadow_total[e] = 32'd1;
      shadow_out[e]   = 32'd1;
      shadow_in[e]    = 32'd0;
      res.status   = StatusNew;
      res.slot     = free_way[1:0];
      res.total    = 32'd1;
      res.outbound = 32'd1;
    end
    return res;
  endfunction

  // Drives one packet and holds it until it is accepted. Valid stays high on return,
  // so the caller either sends the next packet at once or drops valid before idling.
  task automatic send_packet(packet_t pkt);
    s_axis_tdata  <= pkt;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_lookups.push_back(predict_lookup(pkt));
    known_flows.push_back(pkt);
    packets_sent++;
    @(negedge clk_i);
  endtask

  task automatic random_gap();
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  function automatic packet_t random_packet();
    packet_t      pkt;
    logic [127:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    pkt = bits[103:0];
    return pkt;
  endfunction

  function automatic packet_t reversed(packet_t pkt);
    packet_t r;
    r = pkt;
    r.src_addr = pkt.dst_addr;
    r.dst_addr = pkt.src_addr;
    r.src_port = pkt.dst_port;
    r.dst_port = pkt.src_port;
    return r;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_field_extremes();
    packet_t pkt;
    pkt = '0;
    send_packet(pkt);
    send_packet(pkt);
    pkt = '1;
    send_packet(pkt);
    send_packet(reversed(pkt));
    pkt = '{protocol: 8'd6, dst_port: 16'hffff, src_port: 16'h0000,
            dst_addr: 32'hffff_ffff, src_addr: 32'h0000_0000};
    send_packet(pkt);
    send_packet(reversed(pkt));
    send_packet(pkt);
  endtask

  // Symmetric tuples and protocol mismatch on an otherwise reversed key.
  task automatic test_symmetric_and_protocol();
    packet_t pkt;
    pkt = '{protocol: 8'd17, dst_port: 16'd53, src_port: 16'd53,
            dst_addr: 32'h0a00_0001, src_addr: 32'h0a00_0001};
    send_packet(pkt);
    send_packet(pkt);
    pkt = '{protocol: 8'd6, dst_port: 16'd80, src_port: 16'd1234,
            dst_addr: 32'hc0a8_0001, src_addr: 32'hc0a8_0002};
    send_packet(pkt);
    pkt = reversed(pkt);
    pkt.protocol = 8'd7;
    send_packet(pkt);
  endtask

  // Six distinct flows hashing to one bucket fill all ways and then drop.
  task automatic test_bucket_full();
    packet_t pkt;
    pkt = '{protocol: 8'd1, dst_port: 16'd0, src_port: 16'd0,
            dst_addr: 32'd0, src_addr: 32'd0};
    for (int k = 0; k < 6; k++) begin
      // Equal source and destination addresses keep the address XOR at zero, with the ports equal too.
      pkt.src_addr = 32'h1111_0000 + k;
      pkt.dst_addr = 32'h1111_0000 + k;
      send_packet(pkt);
    end
    pkt.src_addr = 32'h1111_0002;
    pkt.dst_addr = 32'h1111_0002;
    send_packet(pkt);
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned count);
    packet_t pkt;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: pkt = random_packet();
        3, 4, 5: pkt = known_flows[$urandom_range(0, known_flows.size() - 1)];
        6, 7:    pkt = reversed(known_flows[$urandom_range(0, known_flows.size() - 1)]);
        default: begin
          // Crowd a handful of buckets so that ways fill and drops occur.
          pkt = random_packet();
          pkt.dst_addr = pkt.src_addr;
          pkt.dst_port = pkt.src_port;
          pkt.protocol = 8'($urandom_range(0, 7));
        end
      endcase
      send_packet(pkt);
      random_gap();
    end
  endtask

  // The receiver holds off while the sender keeps offering, then the sender waits for drain.
  task automatic test_backpressure();
    hold_cycles = 200;
    test_random_traffic(30);
    wait_drained();
  endtask

  // Receiver: a stall pattern of its own, plus a long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_enable) begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    lookup_t got;
    lookup_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (pending_lookups.size() == 0) begin
        $error("result without a pending packet: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (want.status inside {StatusFwdHit, StatusRevHit}) hit_count++;
        if (want.status == StatusDropped) drop_count++;
        if (got.status !== want.status) begin
          $error("lookup_status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.bucket !== want.bucket) begin
          $error("bucket_index: expected %0d, got %0d", want.bucket, got.bucket);
          error_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
          error_count++;
        end
        if (got.total !== want.total) begin
          $error("total_packets: expected %0d, got %0d", want.total, got.total);
          error_count++;
        end
        if (got.outbound !== want.outbound) begin
          $error("outbound_packets: expected %0d, got %0d", want.outbound, got.outbound);
          error_count++;
        end
        if (got.inbound !== want.inbound) begin
          $error("inbound_packets: expected %0d, got %0d", want.inbound, got.inbound);
          error_count++;
        end
      end
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    error_count   = 0;
    packets_sent  = 0;
    results_seen  = 0;
    hit_count     = 0;
    drop_count    = 0;
    hold_cycles   = 0;
    stall_enable  = 1'b0;
    for (int e = 0; e < NumEntries; e++) shadow_valid[e] = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_symmetric_and_protocol();
    test_bucket_full();
    stall_enable = 1'b1;
    test_backpressure();
    test_random_traffic(640);
    stall_enable = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d packets and %0d results: %0d hits, %0d drops.",
             packets_sent, results_seen, hit_count, drop_count);
    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
